### sv/olid_pkg.sv
// ----------------------------------------------------------------------------
// olid_pkg
// Shared types and constants for the ordered list block.
// ----------------------------------------------------------------------------
package olid_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W    = 32;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DELETE  = 2'd1,
    CMD_DISPLAY = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_ENTRY    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_DEL,
    FSM_DISP,
    FSM_RESP
  } fsm_e;

  // controller -> datapath
  typedef struct packed {
    logic    cap;        // capture command value, clear index and match flag
    logic    ins;        // append the command input value at the tail
    logic    rd_first;   // read entry 0
    logic    rd_next;    // read next entry, advance index
    logic    mark_found;
    logic    shift;      // move current entry down by one
    logic    dec_count;
    logic    set_resp;
    status_e resp_status;
    logic    out_entry;  // load output with current entry
    logic    out_resp;   // load output with stored response
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic match;
    logic found;
    logic at_last;
    logic out_free;
  } stat_t;

endpackage

### sv/olid_cmd_if.sv
// ----------------------------------------------------------------------------
// olid_cmd_if
// Command channel: valid/ready handshake with command and value.
// ----------------------------------------------------------------------------
interface olid_cmd_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              command;
  logic signed [31:0]      value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

### sv/olid_res_if.sv
// ----------------------------------------------------------------------------
// olid_res_if
// Result channel: valid/ready handshake with status, entry value and last.
// ----------------------------------------------------------------------------
interface olid_res_if;
  logic                    valid;
  logic                    ready;
  logic [2:0]              status;
  logic signed [31:0]      entry_value;
  logic                    last_result;

  modport source (output valid, output status, output entry_value, output last_result,
                  input ready);
  modport sink   (input valid, input status, input entry_value, input last_result,
                  output ready);
endinterface

### sv/olid_ram.sv
// ----------------------------------------------------------------------------
// olid_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module olid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### sv/olid_ctrl.sv
// ----------------------------------------------------------------------------
// olid_ctrl
// Command sequencer: accepts commands and steps the datapath through
// insert, delete scan/compaction, display and response beats.
// ----------------------------------------------------------------------------
module olid_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      in_command_i,
  output logic            in_ready_o,
  input  olid_pkg::stat_t stat_i,
  output olid_pkg::ctrl_t ctrl_o
);
  import olid_pkg::*;

  fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    ctrl_o.resp_status = ST_DONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.cap = 1'b1;
          unique case (in_command_i)
            CMD_INSERT: begin
              ctrl_o.set_resp = 1'b1;
              if (stat_i.full) begin
                ctrl_o.resp_status = ST_FULL;
              end else begin
                ctrl_o.ins         = 1'b1;
                ctrl_o.resp_status = ST_DONE;
              end
              state_d = FSM_RESP;
            end
            CMD_DELETE, CMD_DISPLAY: begin
              if (stat_i.empty) begin
                ctrl_o.set_resp    = 1'b1;
                ctrl_o.resp_status = ST_EMPTY;
                state_d            = FSM_RESP;
              end else begin
                ctrl_o.rd_first = 1'b1;
                state_d = (in_command_i == CMD_DELETE) ? FSM_DEL : FSM_DISP;
              end
            end
            default: state_d = FSM_IDLE;
          endcase
        end
      end
      FSM_DEL: begin
        if (stat_i.found) begin
          ctrl_o.shift = 1'b1;
        end else if (stat_i.match) begin
          ctrl_o.mark_found = 1'b1;
        end
        if (stat_i.at_last) begin
          ctrl_o.set_resp = 1'b1;
          if (stat_i.found || stat_i.match) begin
            ctrl_o.dec_count   = 1'b1;
            ctrl_o.resp_status = ST_DONE;
          end else begin
            ctrl_o.resp_status = ST_NOTFOUND;
          end
          state_d = FSM_RESP;
        end else begin
          ctrl_o.rd_next = 1'b1;
        end
      end
      FSM_DISP: begin
        if (stat_i.out_free) begin
          ctrl_o.out_entry = 1'b1;
          if (stat_i.at_last) begin
            state_d = FSM_IDLE;
          end else begin
            ctrl_o.rd_next = 1'b1;
          end
        end
      end
      FSM_RESP: begin
        if (stat_i.out_free) begin
          ctrl_o.out_resp = 1'b1;
          state_d         = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_accept_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.cap |-> state_q == FSM_IDLE)
    else $error("command taken outside idle");
  a_resp_follows_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.set_resp |=> state_q == FSM_RESP)
    else $error("response stored but not issued");
  a_one_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_o.out_entry && ctrl_o.out_resp))
    else $error("two output loads in one cycle");
`endif

endmodule

### sv/olid_dp.sv
// ----------------------------------------------------------------------------
// olid_dp
// Datapath: entry store, entry count, scan index, match flag, captured value,
// stored response and the output register.
// ----------------------------------------------------------------------------
module olid_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  olid_pkg::ctrl_t     ctrl_i,
  output olid_pkg::stat_t     stat_o,
  input  logic signed [31:0]  in_value_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output olid_pkg::status_e   out_status_o,
  output logic signed [31:0]  out_value_o,
  output logic                out_last_o
);
  import olid_pkg::*;

  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              found_q, found_d;
  logic              out_valid_q, out_valid_d;
  logic [VAL_W-1:0]  value_q;
  status_e           resp_q;
  status_e           out_status_q;
  logic [VAL_W-1:0]  out_value_q;
  logic              out_last_q;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [VAL_W-1:0]  ram_wdata, ram_rdata;
  logic              out_free;

  olid_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    ram_we    = ctrl_i.ins || ctrl_i.shift;
    ram_waddr = ctrl_i.ins ? count_q[IDX_W-1:0] : idx_q - IDX_W'(1);
    ram_wdata = ctrl_i.ins ? VAL_W'(in_value_i) : ram_rdata;
    ram_re    = ctrl_i.rd_first || ctrl_i.rd_next;
    ram_raddr = ctrl_i.rd_first ? '0 : idx_q + IDX_W'(1);
  end

  always_comb begin
    count_d = count_q;
    if (ctrl_i.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctrl_i.dec_count) begin
      count_d = count_q - CNT_W'(1);
    end
    idx_d = idx_q;
    if (ctrl_i.cap || ctrl_i.rd_first) begin
      idx_d = '0;
    end else if (ctrl_i.rd_next) begin
      idx_d = idx_q + IDX_W'(1);
    end
    found_d = found_q;
    if (ctrl_i.cap) begin
      found_d = 1'b0;
    end else if (ctrl_i.mark_found) begin
      found_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (ctrl_i.out_entry || ctrl_i.out_resp) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap) begin
      value_q <= VAL_W'(in_value_i);
    end
    if (ctrl_i.set_resp) begin
      resp_q <= ctrl_i.resp_status;
    end
    if (ctrl_i.out_entry) begin
      out_status_q <= ST_ENTRY;
      out_value_q  <= ram_rdata;
      out_last_q   <= stat_o.at_last;
    end else if (ctrl_i.out_resp) begin
      out_status_q <= resp_q;
      out_value_q  <= value_q;
      out_last_q   <= 1'b1;
    end
  end

  always_comb begin
    stat_o.empty    = (count_q == '0);
    stat_o.full     = (count_q >= CNT_W'(CAPACITY));
    stat_o.match    = (ram_rdata == value_q);
    stat_o.found    = found_q;
    stat_o.at_last  = (CNT_W'(idx_q) == count_q - CNT_W'(1));
    stat_o.out_free = out_free;
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = $signed(out_value_q);
  assign out_last_o   = out_last_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");
  a_ins_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.ins |-> !stat_o.full)
    else $error("insert into full store");
  a_shift_after_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.shift |-> found_q && idx_q != '0)
    else $error("compaction before a match");
  a_dec_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.dec_count |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("count not decremented");
`endif

endmodule

### sv/ordered_list_insert_delete.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_delete
// Ordered list of up to CAPACITY signed 32-bit values with insert at tail,
// delete of first match with compaction, and display of all entries.
//
// Channels: cmd_i takes one command beat (command, value); res_o returns
// result beats (status, entry_value, last_result), last_result marking the
// final beat of each command. Command code 3 is dropped with no result.
// Insert, and delete or display of an empty list, store one response that
// is loaded into the output register as their one beat once that register
// is free. Delete scans the store one entry per cycle, compacting behind
// the match in the same pass, and then gives its beat the same way. Display
// issues one entry beat per cycle while the receiver keeps ready high. One
// command is handled at a time: the next is accepted once the last beat of
// the current one is loaded into the output register. Reset clears the
// entry count, scan index, match flag and output valid flag; store contents are
// never read before they are written. A stalled receiver holds the output
// beat and the sequencer waits on it; no beat is lost or repeated.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete (
  input  logic clk_i,
  input  logic rst_ni,
  olid_cmd_if.sink   cmd_i,
  olid_res_if.source res_o
);
  import olid_pkg::*;

  ctrl_t   ctrl;
  stat_t   stat;
  status_e out_status;

  olid_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (cmd_i.valid),
    .in_command_i (cmd_i.command),
    .in_ready_o   (cmd_i.ready),
    .stat_i       (stat),
    .ctrl_o       (ctrl)
  );

  olid_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .in_value_i   (cmd_i.value),
    .out_ready_i  (res_o.ready),
    .out_valid_o  (res_o.valid),
    .out_status_o (out_status),
    .out_value_o  (res_o.entry_value),
    .out_last_o   (res_o.last_result)
  );

  assign res_o.status = out_status;

endmodule

### tb/tb_ordered_list_insert_delete.sv
// ----------------------------------------------------------------------------
// tb_ordered_list_insert_delete
// Self-checking bench for the ordered list block. A shadow list tracks every
// accepted command and queues the result beats it should cause. Each beat
// that leaves the block is compared field by field against the oldest one.
// Directed tests cover the empty list, extreme values, duplicates, a miss on
// delete and a full store. They are followed by a long receiver hold-off and
// by random command mixes, some of them with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_ordered_list_insert_delete;
  import olid_pkg::*;

  localparam int          HOLD_CYCLES    = 150;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          DRAIN_CYCLES   = 2 * CAPACITY + 8;
  localparam logic [1:0]  CMD_IGNORED    = 2'd3;
  localparam logic [31:0] VAL_MIN        = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX        = 32'h7fff_ffff;
  localparam logic [31:0] VAL_NEG_ONE    = 32'hffff_ffff;

  typedef struct packed {
    status_e     status;
    logic [31:0] entry_value;
    logic        last_result;
  } beat_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  olid_cmd_if cmd_if ();
  olid_res_if res_if ();

  ordered_list_insert_delete DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .res_o (res_if)
  );

  logic [31:0] list_shadow [CAPACITY];
  int          list_len     = 0;
  beat_t       due_beats [$];
  beat_t       head_beat;
  bit          idle_on      = 1'b1;
  bit          hold_req     = 1'b0;
  int          errors       = 0;
  int          stall_cycles = 0;
  int          n_cmds [4]   = '{0, 0, 0, 0};
  int          n_beats      = 0;
  int          n_full       = 0;
  int          n_empty      = 0;
  int          n_notfound   = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic void expect_beat(input status_e st, input logic [31:0] v,
                                      input logic last);
    beat_t b;
    b.status      = st;
    b.entry_value = v;
    b.last_result = last;
    due_beats.push_back(b);
  endfunction

  // shadow of the list; queues the beats one command should produce
  function automatic void apply_list_cmd(input logic [1:0] c, input logic [31:0] v);
    int pos;
    pos = -1;
    n_cmds[c]++;
    case (c)
      CMD_INSERT: begin
        if (list_len >= CAPACITY) begin
          n_full++;
          expect_beat(ST_FULL, v, 1'b1);
        end else begin
          list_shadow[list_len] = v;
          list_len++;
          expect_beat(ST_DONE, v, 1'b1);
        end
      end
      CMD_DELETE: begin
        for (int i = 0; i < list_len; i++)
          if (pos < 0 && list_shadow[i] == v) pos = i;
        if (list_len == 0) begin
          n_empty++;
          expect_beat(ST_EMPTY, v, 1'b1);
        end else if (pos < 0) begin
          n_notfound++;
          expect_beat(ST_NOTFOUND, v, 1'b1);
        end else begin
          for (int i = pos; i + 1 < list_len; i++) list_shadow[i] = list_shadow[i + 1];
          list_len--;
          expect_beat(ST_DONE, v, 1'b1);
        end
      end
      CMD_DISPLAY: begin
        if (list_len == 0) begin
          n_empty++;
          expect_beat(ST_EMPTY, v, 1'b1);
        end else begin
          for (int i = 0; i < list_len; i++)
            expect_beat(ST_ENTRY, list_shadow[i], i == list_len - 1);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return VAL_NEG_ONE;
      3:       return 32'($urandom_range(0, 7));
      default: return $urandom();
    endcase
  endfunction

  // mostly values that are present, so that deletes hit
  function automatic logic [31:0] pick_delete_value();
    if (list_len > 0 && $urandom_range(0, 9) < 7)
      return list_shadow[$urandom_range(0, list_len - 1)];
    return rand_value();
  endfunction

  task automatic send_cmd(input logic [1:0] c, input logic [31:0] v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      cmd_if.valid   <= 1'b0;
      cmd_if.command <= 2'($urandom());
      cmd_if.value   <= $urandom();
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.command <= c;
    cmd_if.value   <= v;
    do @(posedge clk_i); while (!cmd_if.ready);
    apply_list_cmd(c, v);
  endtask

  // receiver: random stall bursts, or one long hold-off on request
  always begin
    @(posedge clk_i);
    if (hold_req) begin
      hold_req = 1'b0;
      res_if.ready <= 1'b0;
      repeat (HOLD_CYCLES - 1) @(posedge clk_i);
    end else if (idle_on && $urandom_range(0, 2) == 0) begin
      res_if.ready <= 1'b0;
      repeat ($urandom_range(0, 3)) @(posedge clk_i);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      n_beats++;
      if (due_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, got status %0d value %0d last %0d",
                 $time, res_if.status, res_if.entry_value, res_if.last_result);
      end else begin
        head_beat = due_beats.pop_front();
        if (res_if.status !== head_beat.status) begin
          errors++;
          $display("%0t: status error, expected %0d, got %0d",
                   $time, head_beat.status, res_if.status);
        end
        if (res_if.entry_value !== head_beat.entry_value) begin
          errors++;
          $display("%0t: entry_value error, expected %0d, got %0d",
                   $time, $signed(head_beat.entry_value), res_if.entry_value);
        end
        if (res_if.last_result !== head_beat.last_result) begin
          errors++;
          $display("%0t: last_result error, expected %0d, got %0d",
                   $time, head_beat.last_result, res_if.last_result);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, stall_cycles);
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic test_empty_list();
    send_cmd(CMD_DELETE, VAL_MIN);
    send_cmd(CMD_DISPLAY, VAL_MAX);
    send_cmd(CMD_IGNORED, VAL_NEG_ONE);
  endtask

  task automatic test_basic_ops();
    send_cmd(CMD_INSERT, VAL_MIN);
    send_cmd(CMD_INSERT, VAL_MAX);
    send_cmd(CMD_INSERT, '0);
    send_cmd(CMD_INSERT, VAL_NEG_ONE);
    send_cmd(CMD_INSERT, VAL_MAX);
    send_cmd(CMD_INSERT, 32'h5555_5555);
    send_cmd(CMD_INSERT, 32'haaaa_aaaa);
    send_cmd(CMD_DISPLAY, '0);
    // duplicate: only the one nearest the head goes
    send_cmd(CMD_DELETE, VAL_MAX);
    send_cmd(CMD_DELETE, 32'h0000_3039);
    send_cmd(CMD_DELETE, VAL_MIN);
    send_cmd(CMD_DELETE, 32'haaaa_aaaa);
    send_cmd(CMD_IGNORED, VAL_MIN);
    send_cmd(CMD_DISPLAY, VAL_NEG_ONE);
  endtask

  task automatic test_full_list();
    while (list_len < CAPACITY) send_cmd(CMD_INSERT, rand_value());
    send_cmd(CMD_INSERT, VAL_MAX);
    send_cmd(CMD_INSERT, VAL_MIN);
    send_cmd(CMD_DISPLAY, '0);
    send_cmd(CMD_DELETE, list_shadow[CAPACITY - 1]);
    send_cmd(CMD_INSERT, VAL_MIN);
    send_cmd(CMD_DELETE, list_shadow[0]);
    send_cmd(CMD_DISPLAY, VAL_MAX);
  endtask

  task automatic test_stalled_receiver();
    idle_on  = 1'b0;
    hold_req = 1'b1;
    repeat (4) send_cmd(CMD_INSERT, rand_value());
    repeat (3) send_cmd(CMD_DISPLAY, rand_value());
    send_cmd(CMD_DELETE, pick_delete_value());
  endtask

  task automatic test_random_mix(input int n, input bit with_idle);
    int         pick;
    logic [1:0] c;
    idle_on = with_idle;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 4)                               c = CMD_IGNORED;
      else if (pick < 16)                         c = CMD_DISPLAY;
      else if (pick < ((list_len < 12) ? 70 : 50)) c = CMD_INSERT;
      else                                        c = CMD_DELETE;
      send_cmd(c, (c == CMD_DELETE) ? pick_delete_value() : rand_value());
    end
  endtask

  initial begin
    cmd_if.valid   <= 1'b0;
    cmd_if.command <= CMD_INSERT;
    cmd_if.value   <= '0;
    res_if.ready   <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_list();
    test_basic_ops();
    test_full_list();
    test_stalled_receiver();
    test_random_mix(140, 1'b1);
    test_random_mix(50, 1'b0);
    test_random_mix(90, 1'b1);
    test_random_mix(40, 1'b0);

    cmd_if.valid <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Commands: %0d insert, %0d delete, %0d display, %0d ignored; %0d beats checked",
             n_cmds[0], n_cmds[1], n_cmds[2], n_cmds[3], n_beats);
    $display("Special cases seen: %0d full, %0d empty, %0d not found; %0d errors",
             n_full, n_empty, n_notfound, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
